// ===== rtl/psd_digitizer_aggregate_parser_assert.svh =====
// assertion macros for the aggregate parser checker
`ifndef PSD_DIGITIZER_AGGREGATE_PARSER_ASSERT_SVH
`define PSD_DIGITIZER_AGGREGATE_PARSER_ASSERT_SVH

// property checked every cycle outside reset
`define PSDP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked also while reset is high
`define PSDP_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/psdp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package psdp_pkg;

   // word kinds on the result channel
   localparam logic [3:0] KIND_AGG_HDR  = 4'd0;
   localparam logic [3:0] KIND_CH_SIZE  = 4'd1;
   localparam logic [3:0] KIND_CH_FMT   = 4'd2;
   localparam logic [3:0] KIND_TIME_TAG = 4'd3;
   localparam logic [3:0] KIND_SAMPLES  = 4'd4;
   localparam logic [3:0] KIND_EXTRAS   = 4'd5;
   localparam logic [3:0] KIND_CHARGE   = 4'd6;
   localparam logic [3:0] KIND_PADDING  = 4'd7;
   localparam logic [3:0] KIND_IGNORED  = 4'd8;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_ID   = 2'd1;
   localparam logic [1:0] ERR_OVERRUN  = 2'd2;
   localparam logic [1:0] ERR_BANK_END = 2'd3;

   // board aggregate id in the top nibble of header word 0
   localparam logic [3:0] AGG_ID = 4'hA;

   // one decoded input word as it travels from front to back
   typedef struct packed {
      logic [31:0] raw;
      logic        last;
      logic        id_ok;
      logic [27:0] agg_len;
      logic [7:0]  mask;
      logic [21:0] ch_len;
      logic [17:0] swpe;
      logic [17:0] wpe;
   } psdp_word_type;

   // one labeled result
   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  pair;
      logic [1:0]  pos;
      logic [13:0] slo;
      logic [13:0] shi;
      logic [31:0] raw;
      logic        ev_end;
      logic [1:0]  err;
   } psdp_result_type;

endpackage

`default_nettype wire

// ===== rtl/psdp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psdp_front (
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [31:0]           req_data_word,
   input  wire logic                  req_bank_last,
   input  wire logic                  q_full,
   output logic                       q_push,
   output psdp_pkg::psdp_word_type    q_word
);
   import psdp_pkg::*;

   logic [21:0] ch_size;
   logic [17:0] swpe;

   // accept whenever the queue has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // field decode that does not depend on parser state
   assign ch_size = req_data_word[21:0];
   assign swpe    = {req_data_word[15:0], 2'b00};

   always_comb begin
      q_word.raw     = req_data_word;
      q_word.last    = req_bank_last;
      q_word.id_ok   = (req_data_word[31:28] == AGG_ID);
      q_word.agg_len = req_data_word[27:0];
      q_word.mask    = req_data_word[7:0];
      // channel size less the two channel headers, clamped at zero
      q_word.ch_len  = (ch_size >= 22'd2) ? ch_size - 22'd2 : 22'd0;
      q_word.swpe    = swpe;
      q_word.wpe     = swpe + 18'd3;
   end

endmodule

`default_nettype wire

// ===== rtl/psdp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psdp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire psdp_pkg::psdp_word_type push_word,
   output logic                       full,
   input  wire logic                  pop,
   output psdp_pkg::psdp_word_type    pop_word,
   output logic                       not_empty
);
   import psdp_pkg::*;

   psdp_word_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_word  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psdp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module psdp_back #(
   parameter int CHANNEL_GROUPS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_not_empty,
   input  wire psdp_pkg::psdp_word_type q_word,
   output logic                        q_pop,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output psdp_pkg::psdp_result_type   out_result
);
   import psdp_pkg::*;

   // parser phases
   localparam logic [3:0] PH_HDR0   = 4'd0;
   localparam logic [3:0] PH_HDR1   = 4'd1;
   localparam logic [3:0] PH_HDR2   = 4'd2;
   localparam logic [3:0] PH_HDR3   = 4'd3;
   localparam logic [3:0] PH_CHSIZE = 4'd4;
   localparam logic [3:0] PH_CHFMT  = 4'd5;
   localparam logic [3:0] PH_TIME   = 4'd6;
   localparam logic [3:0] PH_SAMP   = 4'd7;
   localparam logic [3:0] PH_EXTRA  = 4'd8;
   localparam logic [3:0] PH_CHARGE = 4'd9;
   localparam logic [3:0] PH_PAD    = 4'd10;
   localparam logic [3:0] PH_IGNORE = 4'd11;

   localparam logic [15:0] GroupMaskWide = (16'd1 << CHANNEL_GROUPS) - 16'd1;
   localparam logic [7:0]  GroupMask     = GroupMaskWide[7:0];

   logic [3:0]  phase_ff, phase_in;
   logic [27:0] seen_ff, seen_in;
   logic [27:0] len_ff, len_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  chan_ff, chan_in;
   logic [21:0] cwl_ff, cwl_in;
   logic [17:0] wpe_ff, wpe_in;
   logic [17:0] swpe_ff, swpe_in;
   logic [17:0] swl_ff, swl_in;
   logic        out_valid_ff;
   psdp_result_type res_ff, res_in;

   logic        fire;
   logic        counted;
   logic [27:0] seen_base;
   logic [7:0]  pick_mask;
   logic        pick_found;
   logic [2:0]  pick_idx;
   logic        do_pick;
   logic [21:0] cwl_cmp;
   logic [17:0] wpe_cmp;

   // lowest pending channel group
   function automatic logic [3:0] lowest_bit(input logic [7:0] m);
      logic [3:0] r;
      r = 4'd0;
      for (int g = 7; g >= 0; g--) begin
         if (m[g]) begin
            r = {1'b1, 3'(g)};
         end
      end
      return r;
   endfunction

   // pop one word when the output register is free or being emptied
   assign fire      = q_not_empty && (!out_valid_ff || out_ready);
   assign q_pop     = fire;
   assign out_valid = out_valid_ff;
   assign out_result = res_ff;

   // parser step for the word at the queue head
   always_comb begin
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      len_in    = len_ff;
      mask_in   = mask_ff;
      chan_in   = chan_ff;
      cwl_in    = cwl_ff;
      wpe_in    = wpe_ff;
      swpe_in   = swpe_ff;
      swl_in    = swl_ff;
      counted   = 1'b1;
      seen_base = seen_ff;
      pick_mask = mask_ff & GroupMask;
      do_pick   = 1'b0;
      cwl_cmp   = cwl_ff;
      wpe_cmp   = wpe_ff;
      pick_found = 1'b0;
      pick_idx   = 3'd0;

      res_in        = '0;
      res_in.kind   = KIND_IGNORED;
      res_in.raw    = q_word.raw;
      res_in.err    = ERR_NONE;

      case (phase_ff)
         PH_HDR0: begin
            if (!q_word.id_ok) begin
               res_in.err = ERR_BAD_ID;
               counted    = 1'b0;
               phase_in   = PH_IGNORE;
            end else begin
               res_in.kind = KIND_AGG_HDR;
               len_in      = q_word.agg_len;
               seen_base   = 28'd0;
               phase_in    = PH_HDR1;
            end
         end
         PH_HDR1: begin
            res_in.kind = KIND_AGG_HDR;
            res_in.pos  = 2'd1;
            mask_in     = q_word.mask & GroupMask;
            phase_in    = PH_HDR2;
         end
         PH_HDR2: begin
            res_in.kind = KIND_AGG_HDR;
            res_in.pos  = 2'd2;
            phase_in    = PH_HDR3;
         end
         PH_HDR3: begin
            res_in.kind = KIND_AGG_HDR;
            res_in.pos  = 2'd3;
            do_pick     = 1'b1;
         end
         PH_CHSIZE: begin
            res_in.kind = KIND_CH_SIZE;
            res_in.pair = chan_ff;
            cwl_in      = q_word.ch_len;
            phase_in    = PH_CHFMT;
         end
         PH_CHFMT: begin
            res_in.kind = KIND_CH_FMT;
            res_in.pair = chan_ff;
            swpe_in     = q_word.swpe;
            wpe_in      = q_word.wpe;
            wpe_cmp     = q_word.wpe;
            if (cwl_cmp >= 22'(wpe_cmp)) begin
               phase_in = PH_TIME;
            end else begin
               pick_mask = mask_ff & ~(8'd1 << chan_ff) & GroupMask;
               do_pick   = 1'b1;
            end
         end
         PH_TIME: begin
            res_in.kind = KIND_TIME_TAG;
            res_in.pair = chan_ff;
            cwl_in      = cwl_ff - 22'(wpe_ff);
            swl_in      = swpe_ff;
            phase_in    = (swpe_ff != 18'd0) ? PH_SAMP : PH_EXTRA;
         end
         PH_SAMP: begin
            res_in.kind = KIND_SAMPLES;
            res_in.pair = chan_ff;
            res_in.slo  = q_word.raw[13:0];
            res_in.shi  = q_word.raw[29:16];
            if (swl_ff != 18'd0) begin
               swl_in = swl_ff - 18'd1;
            end
            if (swl_in == 18'd0) begin
               phase_in = PH_EXTRA;
            end
         end
         PH_EXTRA: begin
            res_in.kind = KIND_EXTRAS;
            res_in.pair = chan_ff;
            phase_in    = PH_CHARGE;
         end
         PH_CHARGE: begin
            res_in.kind   = KIND_CHARGE;
            res_in.pair   = chan_ff;
            res_in.ev_end = 1'b1;
            if (cwl_cmp >= 22'(wpe_cmp)) begin
               phase_in = PH_TIME;
            end else begin
               pick_mask = mask_ff & ~(8'd1 << chan_ff) & GroupMask;
               do_pick   = 1'b1;
            end
         end
         PH_PAD: begin
            res_in.kind = KIND_PADDING;
         end
         default: begin
            counted  = 1'b0;
            phase_in = PH_IGNORE;
         end
      endcase

      // move on to the next channel group, or to padding
      {pick_found, pick_idx} = lowest_bit(pick_mask);
      if (do_pick) begin
         mask_in = pick_mask;
         if (pick_found) begin
            chan_in  = pick_idx;
            phase_in = PH_CHSIZE;
         end else begin
            phase_in = PH_PAD;
         end
      end

      // aggregate size tracking
      if (counted) begin
         seen_in = seen_base + 28'd1;
         if (seen_in >= len_in) begin
            if (phase_in != PH_PAD) begin
               res_in.err = ERR_OVERRUN;
            end
            phase_in = PH_HDR0;
         end
      end

      // bank end
      if (q_word.last) begin
         if (phase_in != PH_HDR0 && phase_in != PH_IGNORE && res_in.err == ERR_NONE) begin
            res_in.err = ERR_BANK_END;
         end
         phase_in = PH_HDR0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         seen_ff  <= '0;
         len_ff   <= '0;
         mask_ff  <= '0;
         chan_ff  <= '0;
         cwl_ff   <= '0;
         wpe_ff   <= '0;
         swpe_ff  <= '0;
         swl_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         len_ff   <= len_in;
         mask_ff  <= mask_in;
         chan_ff  <= chan_in;
         cwl_ff   <= cwl_in;
         wpe_ff   <= wpe_in;
         swpe_ff  <= swpe_in;
         swl_ff   <= swl_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/psd_digitizer_aggregate_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  data_word[31:0], bank_last
// rsp_      out        rsp_valid/rsp_ready  kind, pair, position, samples, raw, end, error
//
// one word per cycle unless rsp_ stalls; words pass the queue, then the output register
// front decodes into a two-entry queue; back parser steps a word per cycle unless stalled
// req_ready drops only when the queue is full, i.e. when rsp_ stalls long enough
// reset is synchronous and clears parser state, queue and output valid

module psd_digitizer_aggregate_parser #(
   parameter int CHANNEL_GROUPS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic        req_bank_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_word_kind,
   output logic [2:0]       rsp_channel_pair,
   output logic [1:0]       rsp_header_position,
   output logic [13:0]      rsp_sample_low,
   output logic [13:0]      rsp_sample_high,
   output logic [31:0]      rsp_raw_word,
   output logic             rsp_event_end,
   output logic [1:0]       rsp_error_code
);
   import psdp_pkg::*;

   psdp_word_type   push_word;
   psdp_word_type   head_word;
   psdp_result_type result;
   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_not_empty;

   // decode and accept
   psdp_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_word (req_data_word),
      .req_bank_last (req_bank_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_word        (push_word)
   );

   // decoupling queue
   psdp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .pop_word  (head_word),
      .not_empty (q_not_empty)
   );

   // parser and output register
   psdp_back #(
      .CHANNEL_GROUPS (CHANNEL_GROUPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_word      (head_word),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_result  (result)
   );

   assign rsp_word_kind       = result.kind;
   assign rsp_channel_pair    = result.pair;
   assign rsp_header_position = result.pos;
   assign rsp_sample_low      = result.slo;
   assign rsp_sample_high     = result.shi;
   assign rsp_raw_word        = result.raw;
   assign rsp_event_end       = result.ev_end;
   assign rsp_error_code      = result.err;

endmodule

`default_nettype wire

// ===== rtl/psdp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "psd_digitizer_aggregate_parser_assert.svh"

module psdp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_word_kind,
   input wire logic [1:0]  rsp_header_position,
   input wire logic [13:0] rsp_sample_low,
   input wire logic [13:0] rsp_sample_high,
   input wire logic [31:0] rsp_raw_word,
   input wire logic        rsp_event_end,
   input wire logic [1:0]  rsp_error_code
);
   import psdp_pkg::*;

   // stalled transaction holds its valid, raw word and kind
   `PSDP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_word) && $stable(rsp_word_kind), "rsp transaction changed while stalled")

   // no result right after reset
   `PSDP_ASSERT_RST(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp_valid high after reset")

   // event end only on a charge word
   `PSDP_ASSERT(a_event_end, clock, reset, rsp_valid && rsp_event_end |-> rsp_word_kind == KIND_CHARGE, "event end on a non-charge word")

   // samples zero except on sample words, header position zero except on header words
   `PSDP_ASSERT(a_samples, clock, reset, rsp_valid && rsp_word_kind != KIND_SAMPLES |-> rsp_sample_low == 14'd0 && rsp_sample_high == 14'd0 && (rsp_header_position == 2'd0 || rsp_word_kind == KIND_AGG_HDR), "stray sample or header position")

   // bad id is reported on an ignored word
   `PSDP_ASSERT(a_bad_id, clock, reset, rsp_valid && rsp_error_code == ERR_BAD_ID |-> rsp_word_kind == KIND_IGNORED, "bad id on a labeled word")

endmodule

bind psd_digitizer_aggregate_parser psdp_checker u_psdp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_word_kind       (rsp_word_kind),
   .rsp_header_position (rsp_header_position),
   .rsp_sample_low      (rsp_sample_low),
   .rsp_sample_high     (rsp_sample_high),
   .rsp_raw_word        (rsp_raw_word),
   .rsp_event_end       (rsp_event_end),
   .rsp_error_code      (rsp_error_code)
);

`default_nettype wire
